[rtl/core/blep_pkg.sv]
// types, constants and helper functions for the button and level event packetizer
`default_nettype none

package blep_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int NUM_LEVELS  = 10;
  localparam int MAP_COUNT   = 6;

  localparam int PIN_W    = 5;
  localparam int MASK_W   = 4;
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int DEB_W    = 16;
  localparam int STEP_W   = 12;
  localparam int BYTE_W   = 8;

  localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int LEVEL_W   = $clog2(NUM_LEVELS);
  localparam int THR_W     = STEP_W + LEVEL_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DEB_W;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 1'b1;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_LEVEL = 1'b1;

  localparam logic [MASK_W-1:0] FALL_MASK  = 4'h4;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'hFF;
  localparam logic [BYTE_W-1:0] LEVEL_CODE = 8'd7;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd200;
  localparam logic [STEP_W-1:0] STEP_RESET     = 12'd400;

  localparam int PKT_BYTES = 4;
  localparam int CNT_W     = $clog2(PKT_BYTES);

  localparam logic [CNT_W-1:0] BYTE_CODE = 2'd0;
  localparam logic [CNT_W-1:0] BYTE_PAD  = 2'd1;
  localparam logic [CNT_W-1:0] BYTE_DATA = 2'd2;
  localparam logic [CNT_W-1:0] BYTE_END  = 2'd3;

  typedef logic [PIN_W-1:0] pin_map_t [MAP_COUNT];
  localparam pin_map_t BUTTON_PINS = '{5'd15, 5'd14, 5'd12, 5'd17, 5'd16, 5'd13};

  typedef struct packed {
    logic                command;
    logic [PIN_W-1:0]    pin;
    logic [MASK_W-1:0]   edge_events;
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } out_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] data;
  } pkt_t;

  typedef struct packed {
    logic                 hit;
    logic [BTN_IDX_W-1:0] idx;
  } btn_hit_t;

  typedef logic [NUM_LEVELS-2:0][THR_W-1:0] thr_table_t;

  // level k starts at k * step, zero step acts as one
  function automatic thr_table_t level_thresholds(input logic [STEP_W-1:0] step);
    thr_table_t        t;
    logic [STEP_W-1:0] s;
    s = (step == '0) ? STEP_W'(1) : step;
    for (int i = 0; i < NUM_LEVELS - 1; i++) begin
      t[i] = THR_W'(s) * THR_W'(i + 1);
    end
    return t;
  endfunction

  // first matching map entry wins
  function automatic btn_hit_t button_lookup(input logic [PIN_W-1:0] pin);
    btn_hit_t r;
    r = '0;
    for (int i = MAP_COUNT - 1; i >= 0; i--) begin
      if (BUTTON_PINS[i] == pin && i < NUM_BUTTONS) begin
        r.hit = 1'b1;
        r.idx = BTN_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/blep_cfg.sv]
// configuration registers and precomputed level threshold table
`default_nettype none

module blep_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [blep_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [blep_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic      [blep_pkg::DEB_W-1:0]       debounce_ms,
  output blep_pkg::thr_table_t                  thresholds
);
  import blep_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      thresholds  <= level_thresholds(STEP_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   debounce_ms <= cfg_wdata[DEB_W-1:0];
        REG_LEVEL_STEP: thresholds  <= level_thresholds(cfg_wdata[STEP_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/blep_eval.sv]
// input register, debounce and level state, and packet decision
`default_nettype none

module blep_eval (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire blep_pkg::in_word_t          in_word,
  input  wire logic [blep_pkg::DEB_W-1:0]  debounce_ms,
  input  wire blep_pkg::thr_table_t        thresholds,
  output logic                             pkt_valid,
  output blep_pkg::pkt_t                   pkt,
  input  wire logic                        ser_ready
);
  import blep_pkg::*;

  in_word_t                             s1;
  logic                                 s1_valid;
  logic [NUM_BUTTONS-1:0][TIME_W-1:0]   last_time;
  logic [LEVEL_W-1:0]                   previous_level;

  btn_hit_t                             btn;
  logic [TIME_W-1:0]                    elapsed;
  logic                                 btn_pass;
  logic [NUM_LEVELS-2:0]                above;
  logic [LEVEL_W-1:0]                   level;
  logic                                 level_pass;
  logic                                 fire;

  always_comb begin
    btn      = button_lookup(s1.pin);
    elapsed  = s1.time_ms - last_time[btn.idx];
    btn_pass = (s1.command == CMD_EDGE) && (s1.edge_events == FALL_MASK) && btn.hit &&
               (elapsed > TIME_W'(debounce_ms));
    for (int i = 0; i < NUM_LEVELS - 1; i++) begin
      above[i] = THR_W'(s1.sample) >= thresholds[i];
    end
    level      = LEVEL_W'($countones(above));
    level_pass = (s1.command == CMD_LEVEL) && (level != previous_level);
  end

  always_comb begin
    pkt_valid = s1_valid && (btn_pass || level_pass);
    if (s1.command == CMD_LEVEL) begin
      pkt.code = LEVEL_CODE;
      pkt.data = BYTE_W'(level);
    end else begin
      pkt.code = BYTE_W'(btn.idx) + BYTE_W'(1);
      pkt.data = '0;
    end
    fire     = pkt_valid && ser_ready;
    in_ready = !pkt_valid || ser_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      last_time      <= '0;
      previous_level <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (fire && btn_pass) begin
        last_time[btn.idx] <= s1.time_ms;
      end
      if (fire && level_pass) begin
        previous_level <= level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_word;
    end
  end

  a_stamp: assert property (@(posedge clk) disable iff (rst)
    fire && btn_pass |=> last_time[$past(btn.idx)] == $past(s1.time_ms))
    else $error("button time not stamped");

  a_level: assert property (@(posedge clk) disable iff (rst)
    fire && level_pass |=> previous_level == $past(level))
    else $error("level not remembered");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !in_ready |=> s1_valid && $stable(s1))
    else $error("stalled word lost");

endmodule

`default_nettype wire

[rtl/core/blep_ser.sv]
// packet buffer and four-word serializer
`default_nettype none

module blep_ser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pkt_valid,
  input  wire blep_pkg::pkt_t     pkt,
  output logic                    ser_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output blep_pkg::out_word_t     out_word
);
  import blep_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W-1:0] code;
  logic [BYTE_W-1:0] data;
  logic              last;

  assign last      = (cnt == BYTE_END);
  assign ser_ready = !busy || (out_ready && last);
  assign out_valid = busy;

  always_comb begin
    out_word.last_byte = last;
    unique case (cnt)
      BYTE_CODE: out_word.out_byte = code;
      BYTE_PAD:  out_word.out_byte = '0;
      BYTE_DATA: out_word.out_byte = data;
      BYTE_END:  out_word.out_byte = END_MARK;
      default:   out_word.out_byte = END_MARK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pkt_valid && ser_ready) begin
      busy <= 1'b1;
      cnt  <= BYTE_CODE;
    end else if (busy && out_ready) begin
      cnt <= cnt + CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && ser_ready) begin
      code <= pkt.code;
      data <= pkt.data;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> cnt == BYTE_CODE)
    else $error("packet does not start at first word");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |=> busy && $stable(cnt) && $stable(code) && $stable(data))
    else $error("word changed while stalled");

  a_step: assert property (@(posedge clk) disable iff (rst)
    busy && out_ready && !last |=> busy && cnt == $past(cnt) + CNT_W'(1))
    else $error("word counter skipped");

endmodule

`default_nettype wire

[rtl/core/button_level_event_packetizer.sv]
// top level of the button and level event packetizer
`default_nettype none

// Takes button edge words and level sample words and sends four-word report
// packets. An input word is registered, then evaluated combinationally (debounce
// check against the per-button last press time, or quantization by compare
// against a threshold table built at reset and when level_step is written), and
// a passing word loads a packet buffer that sends code, 0, data, 0xFF. A word
// that gives no packet does not hold the input, and the next input word is taken
// while the current packet drains, so when every word reports, the sustained
// rate is set by the output, one word per cycle while out_ready is high.
// Configuration takes effect on the next cycle.

module button_level_event_packetizer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire blep_pkg::in_word_t               in_word,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output blep_pkg::out_word_t                   out_word,
  input  wire logic                             cfg_we,
  input  wire logic [blep_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [blep_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import blep_pkg::*;

  logic [DEB_W-1:0] debounce_ms;
  thr_table_t       thresholds;
  logic             pkt_valid;
  pkt_t             pkt;
  logic             ser_ready;

  blep_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .debounce_ms (debounce_ms),
    .thresholds  (thresholds)
  );

  blep_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .debounce_ms (debounce_ms),
    .thresholds  (thresholds),
    .pkt_valid   (pkt_valid),
    .pkt         (pkt),
    .ser_ready   (ser_ready)
  );

  blep_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .ser_ready (ser_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

[sim/tb_button_level_event_packetizer.sv]
// self-checking testbench for the button and level event packetizer
`timescale 1ns / 100ps

module tb_button_level_event_packetizer;
  import blep_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_WORDS    = 28;
  localparam int MAX_REPORTS    = 10;

  class event_packet_scoreboard;
    logic [DEB_W-1:0]    debounce;
    logic [STEP_W-1:0]   level_step;
    logic [TIME_W-1:0]   last_press [NUM_BUTTONS];
    logic [LEVEL_W-1:0]  prev_level;
    out_word_t           expected_words [$];
    int                  mismatches;

    function new();
      debounce   = DEBOUNCE_RESET;
      level_step = STEP_RESET;
      foreach (last_press[i]) last_press[i] = '0;
      prev_level  = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_DEBOUNCE) debounce = data[DEB_W-1:0];
      else if (addr == REG_LEVEL_STEP) level_step = data[STEP_W-1:0];
    endfunction

    function void queue_packet(logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] data);
      expected_words.push_back('{out_byte: code, last_byte: 1'b0});
      expected_words.push_back('{out_byte: '0, last_byte: 1'b0});
      expected_words.push_back('{out_byte: data, last_byte: 1'b0});
      expected_words.push_back('{out_byte: END_MARK, last_byte: 1'b1});
    endfunction

    function void note_word(in_word_t w);
      int                button;
      logic [TIME_W-1:0] elapsed;
      int unsigned       divisor;
      int unsigned       lvl;
      if (w.command == CMD_EDGE) begin
        if (w.edge_events != FALL_MASK) return;
        button = -1;
        for (int i = 0; i < MAP_COUNT; i++) begin
          if (button < 0 && BUTTON_PINS[i] == w.pin) button = i;
        end
        if (button < 0 || button >= NUM_BUTTONS) return;
        elapsed = w.time_ms - last_press[button];
        if (elapsed <= TIME_W'(debounce)) return;
        last_press[button] = w.time_ms;
        queue_packet(BYTE_W'(button + 1), '0);
      end else begin
        divisor = (level_step == '0) ? 1 : int'(level_step);
        lvl = int'(w.sample) / divisor;
        if (lvl > NUM_LEVELS - 1) lvl = NUM_LEVELS - 1;
        if (LEVEL_W'(lvl) == prev_level) return;
        prev_level = LEVEL_W'(lvl);
        queue_packet(LEVEL_CODE, BYTE_W'(lvl));
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word byte=%02h last=%0b", $realtime, got.out_byte,
                   got.last_byte);
        return;
      end
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: word mismatch byte exp=%02h got=%02h last exp=%0b got=%0b",
                   $realtime, want.out_byte, got.out_byte, want.last_byte, got.last_byte);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic calm = 1'b0;
  int   idle_cycles = 0;

  event_packet_scoreboard sb = new();

  button_level_event_packetizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_word);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t edge_word(logic [PIN_W-1:0] pin, logic [MASK_W-1:0] mask,
                                         logic [TIME_W-1:0] stamp);
    in_word_t w;
    w.command     = CMD_EDGE;
    w.pin         = pin;
    w.edge_events = mask;
    w.time_ms     = stamp;
    w.sample      = SAMPLE_W'($urandom_range(0, 4095));
    return w;
  endfunction

  function automatic in_word_t level_word(logic [SAMPLE_W-1:0] sample);
    in_word_t w;
    w.command     = CMD_LEVEL;
    w.pin         = PIN_W'($urandom_range(0, 31));
    w.edge_events = MASK_W'($urandom_range(0, 15));
    w.time_ms     = $urandom;
    w.sample      = sample;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [DEB_W-1:0] deb, logic [STEP_W-1:0] step);
    logic [CFG_DATA_W-1:0] step_data;
    step_data = {4'($urandom_range(0, 15)), step};
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_addr  <= REG_LEVEL_STEP;
    cfg_wdata <= step_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_DEBOUNCE, deb);
    sb.write_reg(REG_LEVEL_STEP, step_data);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    int                good;
    int                pick;
    int                idx;
    int unsigned       deb;
    logic [TIME_W-1:0] stamp;
    in_word_t          w;
    good = 0;
    while (good < count) begin
      pick = $urandom_range(0, 99);
      deb  = sb.debounce;
      if (pick < 12) begin
        // noise and broken edges
        w.command     = 1'($urandom_range(0, 1));
        w.pin         = PIN_W'($urandom_range(0, 31));
        w.edge_events = MASK_W'($urandom_range(0, 15));
        w.time_ms     = $urandom;
        w.sample      = SAMPLE_W'($urandom_range(0, 4095));
      end else if (pick < 56) begin
        idx = $urandom_range(0, NUM_BUTTONS - 1);
        case ($urandom_range(0, 9))
          0: stamp = $urandom;
          1: stamp = sb.last_press[idx] + deb;
          2: stamp = sb.last_press[idx] + deb + 1;
          default: stamp = sb.last_press[idx] + $urandom_range(0, 2 * deb + 3);
        endcase
        w = edge_word(BUTTON_PINS[idx], FALL_MASK, stamp);
        good++;
      end else begin
        w = level_word(SAMPLE_W'($urandom_range(0, 4095)));
        good++;
      end
      send_word(w);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // early presses against reset times, debounce boundary
    send_word(edge_word(5'd15, FALL_MASK, 32'd0));
    send_word(edge_word(5'd15, FALL_MASK, 32'd200));
    send_word(edge_word(5'd15, FALL_MASK, 32'd201));
    send_word(edge_word(5'd15, FALL_MASK, 32'd401));
    send_word(edge_word(5'd15, FALL_MASK, 32'd402));
    for (int i = 1; i < MAP_COUNT; i++) send_word(edge_word(BUTTON_PINS[i], FALL_MASK, 32'd1000));
    // unmapped pins and other masks
    send_word(edge_word(5'd0, FALL_MASK, 32'd5000));
    send_word(edge_word(5'd31, FALL_MASK, 32'd5000));
    send_word(edge_word(5'd11, FALL_MASK, 32'd5000));
    send_word(edge_word(5'd15, 4'h0, 32'd10000));
    send_word(edge_word(5'd15, 4'hF, 32'd10000));
    send_word(edge_word(5'd15, 4'h5, 32'd10000));
    // timestamp wrap
    send_word(edge_word(5'd15, FALL_MASK, 32'hFFFF_FFFF));
    send_word(edge_word(5'd15, FALL_MASK, 32'd100));
    send_word(edge_word(5'd15, FALL_MASK, 32'd200));
    // levels: unchanged, boundaries, saturation
    send_word(level_word(12'd0));
    send_word(level_word(12'd399));
    send_word(level_word(12'd400));
    send_word(level_word(12'd4095));
    send_word(level_word(12'd3600));
    send_word(level_word(12'd3599));
    send_word(level_word(12'd0));
    wait_drained();

    set_config(16'd0, 12'd0);
    run_phase(PHASE_WORDS);
    wait_drained();

    set_config(16'hFFFF, 12'hFFF);
    run_phase(PHASE_WORDS);
    wait_drained();

    calm <= 1'b1;
    set_config(DEB_W'($urandom_range(1, 1000)), STEP_W'($urandom_range(100, 500)));
    run_phase(PHASE_WORDS);
    wait_drained();
    calm <= 1'b0;

    set_config(16'd1, 12'd1);
    run_phase(PHASE_WORDS);
    wait_drained();

    set_config(DEB_W'($urandom_range(0, 65535)), STEP_W'($urandom_range(1, 4095)));
    run_phase(PHASE_WORDS);
    wait_drained();

    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/blep_pkg.sv
rtl/core/blep_cfg.sv
rtl/core/blep_eval.sv
rtl/core/blep_ser.sv
rtl/core/button_level_event_packetizer.sv
sim/tb_button_level_event_packetizer.sv
